### src/psups_pkg.sv
`default_nettype none

package psups_pkg;

	localparam int FRAME_BYTES = 64;
	localparam int POS_W = $clog2(FRAME_BYTES);

	localparam int SAMPLE_W = 12;
	localparam int SCALE_W = 32;
	localparam int POWER_W = 28;
	localparam int PROD_W = SAMPLE_W + SCALE_W;
	localparam int POWER_LSB = 16;
	localparam int SQ_W = 2 * POWER_W;
	localparam int TIME_W = 48;
	localparam int COUNT_W = 32;
	localparam int SUM_W = 64;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_POWER_SCALE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SECOND_TICKS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STATS_ENABLE = 2'd2;

	localparam logic [31:0] POWER_SCALE_RST = 32'd377673;
	localparam logic [31:0] SECOND_TICKS_RST = 32'd1000000;

	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef struct packed {
		logic load_period;
		logic load_low_a;
		logic load_low_b;
		logic load_samples;
		logic do_mul;
		logic do_sq;
		logic do_close;
		logic do_acc;
		logic sel_b;
		logic last;
	} cmd_t;

	typedef struct packed {
		logic close_emit;
		logic room;
	} sts_t;

endpackage

`default_nettype wire

### src/psups_ctrl.sv
`default_nettype none

module psups_ctrl (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     in_valid,
	output logic                    in_ready,
	input  psups_pkg::sts_t         sts,
	output psups_pkg::cmd_t         cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MUL   = 3'd1;
	localparam logic [2:0] ST_SQ    = 3'd2;
	localparam logic [2:0] ST_CLOSE = 3'd3;
	localparam logic [2:0] ST_ACC   = 3'd4;

	localparam logic [1:0] PH_LOW_A = 2'd0;
	localparam logic [1:0] PH_LOW_B = 2'd1;
	localparam logic [1:0] PH_NIB   = 2'd2;

	logic [2:0] state_q, state_d;
	logic [psups_pkg::POS_W-1:0] pos_q;
	logic [1:0] phase_q;
	logic sel_b_q;
	logic in_fire;
	logic [psups_pkg::POS_W:0] pos_inc;

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire = in_valid && in_ready;
	assign pos_inc = {1'b0, pos_q} + {{psups_pkg::POS_W{1'b0}}, 1'b1};

	always_comb begin
		cmd = '0;
		cmd.sel_b = sel_b_q;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (pos_q == '0) begin
						cmd.load_period = 1'b1;
					end else begin
						case (phase_q)
							PH_LOW_A: cmd.load_low_a = 1'b1;
							PH_LOW_B: cmd.load_low_b = 1'b1;
							default: begin
								cmd.load_samples = 1'b1;
								state_d = ST_MUL;
							end
						endcase
					end
				end
			end
			ST_MUL: begin
				cmd.do_mul = 1'b1;
				state_d = ST_SQ;
			end
			ST_SQ: begin
				cmd.do_sq = 1'b1;
				state_d = ST_CLOSE;
			end
			ST_CLOSE: begin
				// hold while a summary has nowhere to go
				if (!sts.close_emit || sts.room) begin
					cmd.do_close = 1'b1;
					state_d = ST_ACC;
				end
			end
			ST_ACC: begin
				if (sts.room) begin
					cmd.do_acc = 1'b1;
					cmd.last = sel_b_q;
					state_d = sel_b_q ? ST_IDLE : ST_MUL;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q <= '0;
			phase_q <= PH_LOW_A;
			sel_b_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_fire) begin
				if (pos_inc >= psups_pkg::FRAME_BYTES[psups_pkg::POS_W:0]) begin
					pos_q <= '0;
				end else begin
					pos_q <= pos_inc[psups_pkg::POS_W-1:0];
				end
				if (pos_q == '0 || phase_q == PH_NIB) begin
					phase_q <= PH_LOW_A;
				end else begin
					phase_q <= phase_q + 2'd1;
				end
			end
			if (cmd.load_samples) begin
				sel_b_q <= 1'b0;
			end else if (cmd.do_acc) begin
				sel_b_q <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### src/psups_dp.sv
`default_nettype none

module psups_dp (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire  [7:0]                           byte_value,
	input  wire                                  cfg_valid,
	input  wire  [psups_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [psups_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  psups_pkg::cmd_t                      cmd,
	output psups_pkg::sts_t                      sts,
	output logic                                 out_valid,
	input  wire                                  out_ready,
	output logic                                 kind,
	output logic [psups_pkg::POWER_W-1:0]        power,
	output logic [psups_pkg::TIME_W-1:0]         timestamp,
	output logic [psups_pkg::COUNT_W-1:0]        window_count,
	output logic [psups_pkg::SUM_W-1:0]          window_sum,
	output logic [psups_pkg::SUM_W-1:0]          window_sum_squares,
	output logic [psups_pkg::POWER_W-1:0]        window_min,
	output logic [psups_pkg::POWER_W-1:0]        window_max,
	output logic                                 last
);

	localparam int TW = psups_pkg::TIME_W;
	localparam int PW = psups_pkg::POWER_W;
	localparam int SW = psups_pkg::SUM_W;
	localparam int CW = psups_pkg::COUNT_W;

	logic [psups_pkg::SCALE_W-1:0] power_scale_q;
	logic [31:0] second_ticks_q;
	logic stats_enable_q;

	logic [7:0] period_q, low_a_q, low_b_q;
	logic [psups_pkg::SAMPLE_W-1:0] samp_a_q, samp_b_q, samp_sel;
	logic [psups_pkg::PROD_W-1:0] prod;
	logic [PW-1:0] p_q;
	logic [psups_pkg::SQ_W-1:0] sq_q;
	logic close_q;
	logic [TW-1:0] cur_time_q, ws_q, age;

	logic [CW-1:0] acc_count_q;
	logic [SW-1:0] acc_sum_q, acc_sq_q;
	logic [PW-1:0] acc_min_q, acc_max_q;
	logic [SW:0] sum_next, sq_next;

	logic out_valid_q, emit_summary;

	assign samp_sel = cmd.sel_b ? samp_b_q : samp_a_q;
	assign prod = {{psups_pkg::SCALE_W{1'b0}}, samp_sel} * {{psups_pkg::SAMPLE_W{1'b0}}, power_scale_q};
	assign age = cur_time_q - ws_q;
	assign sum_next = {1'b0, acc_sum_q} + {{(SW+1-PW){1'b0}}, p_q};
	assign sq_next = {1'b0, acc_sq_q} + {{(SW+1-psups_pkg::SQ_W){1'b0}}, sq_q};
	assign emit_summary = cmd.do_close && close_q && stats_enable_q;

	// close_emit, room
	assign sts = {close_q && stats_enable_q, !out_valid_q || out_ready};
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_scale_q <= psups_pkg::POWER_SCALE_RST;
			second_ticks_q <= psups_pkg::SECOND_TICKS_RST;
			stats_enable_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				psups_pkg::REG_POWER_SCALE: power_scale_q <= cfg_data;
				psups_pkg::REG_SECOND_TICKS: second_ticks_q <= cfg_data;
				psups_pkg::REG_STATS_ENABLE: stats_enable_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= '0;
			low_a_q <= '0;
			low_b_q <= '0;
			cur_time_q <= '0;
			ws_q <= '0;
			close_q <= 1'b0;
			acc_count_q <= '0;
			acc_sum_q <= '0;
			acc_sq_q <= '0;
			acc_min_q <= '1;
			acc_max_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_period) period_q <= byte_value;
			if (cmd.load_low_a) low_a_q <= byte_value;
			if (cmd.load_low_b) low_b_q <= byte_value;
			if (cmd.do_mul) close_q <= age > {{(TW-32){1'b0}}, second_ticks_q};
			if (cmd.do_close && close_q) begin
				acc_count_q <= '0;
				acc_sum_q <= '0;
				acc_sq_q <= '0;
				acc_min_q <= '1;
				acc_max_q <= '0;
				ws_q <= ws_q + {{(TW-32){1'b0}}, second_ticks_q};
			end
			if (cmd.do_acc) begin
				if (acc_count_q != '1) acc_count_q <= acc_count_q + 1'b1;
				acc_sum_q <= sum_next[SW] ? '1 : sum_next[SW-1:0];
				acc_sq_q <= sq_next[SW] ? '1 : sq_next[SW-1:0];
				if (p_q < acc_min_q) acc_min_q <= p_q;
				if (p_q > acc_max_q) acc_max_q <= p_q;
				cur_time_q <= cur_time_q + {{(TW-8){1'b0}}, period_q};
			end
			if (emit_summary || cmd.do_acc) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_samples) begin
			samp_a_q <= {byte_value[3:0], low_a_q};
			samp_b_q <= {byte_value[7:4], low_b_q};
		end
		if (cmd.do_mul) p_q <= prod[psups_pkg::POWER_LSB +: PW];
		if (cmd.do_sq) sq_q <= p_q * p_q;
		if (emit_summary) begin
			kind <= psups_pkg::KIND_SUMMARY;
			power <= '0;
			timestamp <= ws_q;
			window_count <= acc_count_q;
			window_sum <= acc_sum_q;
			window_sum_squares <= acc_sq_q;
			window_min <= acc_min_q;
			window_max <= acc_max_q;
			last <= 1'b0;
		end else if (cmd.do_acc) begin
			kind <= psups_pkg::KIND_SAMPLE;
			power <= p_q;
			timestamp <= cur_time_q;
			window_count <= '0;
			window_sum <= '0;
			window_sum_squares <= '0;
			window_min <= '0;
			window_max <= '0;
			last <= cmd.last;
		end
	end

endmodule

`default_nettype wire

### src/packed_sample_unpack_power_stats.sv
// Period and low bytes: one byte per cycle, no results.
// Nibble byte: two samples, each through multiply, square, window close and accumulate
// (the last two wait for output room); a window summary is registered in the close step,
// the sample in the accumulate step, and the next byte is taken after both samples.
// Reset: registers return to their defaults, frame position, time and window clear.
`default_nettype none

module packed_sample_unpack_power_stats (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  in_valid,
	output logic                                 in_ready,
	input  wire  [7:0]                           byte_value,
	input  wire                                  cfg_valid,
	output logic                                 cfg_ready,
	input  wire  [psups_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [psups_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic                                 out_valid,
	input  wire                                  out_ready,
	output logic                                 kind,
	output logic [psups_pkg::POWER_W-1:0]        power,
	output logic [psups_pkg::TIME_W-1:0]         timestamp,
	output logic [psups_pkg::COUNT_W-1:0]        window_count,
	output logic [psups_pkg::SUM_W-1:0]          window_sum,
	output logic [psups_pkg::SUM_W-1:0]          window_sum_squares,
	output logic [psups_pkg::POWER_W-1:0]        window_min,
	output logic [psups_pkg::POWER_W-1:0]        window_max,
	output logic                                 last
);

	psups_pkg::cmd_t cmd;
	psups_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	psups_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	psups_dp u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.byte_value         (byte_value),
		.cfg_valid          (cfg_valid),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.cmd                (cmd),
		.sts                (sts),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.kind               (kind),
		.power              (power),
		.timestamp          (timestamp),
		.window_count       (window_count),
		.window_sum         (window_sum),
		.window_sum_squares (window_sum_squares),
		.window_min         (window_min),
		.window_max         (window_max),
		.last               (last)
	);

endmodule

`default_nettype wire

### dv/tb_top.sv
module tb_top;
	import psups_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int LONG_HOLD = 300;
	localparam int STALL_LIMIT = 3000;
	localparam int SETTLE_CYCLES = 20;
	localparam int TAIL_CYCLES = 40;

	typedef struct packed {
		logic                kind;
		logic [POWER_W-1:0]  power;
		logic [TIME_W-1:0]   stamp;
		logic [COUNT_W-1:0]  wcount;
		logic [SUM_W-1:0]    wsum;
		logic [SUM_W-1:0]    wsumsq;
		logic [POWER_W-1:0]  wmin;
		logic [POWER_W-1:0]  wmax;
		logic                last;
	} power_record_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic [7:0]            byte_value = 8'h00;
	logic                  cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  out_ready = 1'b0;

	logic                  in_ready;
	logic                  cfg_ready;
	logic                  out_valid;
	logic                  kind;
	logic [POWER_W-1:0]    power;
	logic [TIME_W-1:0]     timestamp;
	logic [COUNT_W-1:0]    window_count;
	logic [SUM_W-1:0]      window_sum;
	logic [SUM_W-1:0]      window_sum_squares;
	logic [POWER_W-1:0]    window_min;
	logic [POWER_W-1:0]    window_max;
	logic                  last;

	packed_sample_unpack_power_stats i_dut (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.byte_value         (byte_value),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.kind               (kind),
		.power              (power),
		.timestamp          (timestamp),
		.window_count       (window_count),
		.window_sum         (window_sum),
		.window_sum_squares (window_sum_squares),
		.window_min         (window_min),
		.window_max         (window_max),
		.last               (last)
	);

	// stream unpacker and window statistics, mirrored at the block's widths
	logic [31:0]        cfg_scale;
	logic [31:0]        cfg_window;
	logic               cfg_stats;
	logic [POS_W-1:0]   frm_pos;
	logic [7:0]         period_q;
	logic [7:0]         low_a;
	logic [7:0]         low_b;
	logic [TIME_W-1:0]  now_ticks;
	logic [TIME_W-1:0]  win_start;
	logic [COUNT_W-1:0] win_cnt;
	logic [SUM_W-1:0]   win_sum;
	logic [SUM_W-1:0]   win_sq;
	logic [POWER_W-1:0] win_min;
	logic [POWER_W-1:0] win_max;

	power_record_t predicted_records[$];
	logic [7:0]    stream_bytes[$];

	int bytes_sent = 0;
	int bytes_in = 0;
	int gen_pos = 0;
	int n_samples = 0;
	int n_summaries = 0;
	int cfg_writes = 0;
	int mismatches = 0;
	int hold_left = 0;
	int stall_cycles = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
			input logic [SUM_W-1:0] b);
		logic [SUM_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[SUM_W] ? '1 : s[SUM_W-1:0];
	endfunction

	task automatic clear_window();
		win_cnt = '0;
		win_sum = '0;
		win_sq = '0;
		win_min = '1;
		win_max = '0;
	endtask

	task automatic reset_predictor();
		cfg_scale = POWER_SCALE_RST;
		cfg_window = SECOND_TICKS_RST;
		cfg_stats = 1'b0;
		frm_pos = '0;
		period_q = '0;
		low_a = '0;
		low_b = '0;
		now_ticks = '0;
		win_start = '0;
		clear_window();
	endtask

	task automatic convert_sample(input logic [SAMPLE_W-1:0] s12, input logic is_last);
		logic [PROD_W-1:0]  prod;
		logic [POWER_W-1:0] pwr;
		power_record_t      rec;
		prod = PROD_W'(s12) * PROD_W'(cfg_scale);
		pwr = prod[PROD_W-1:POWER_LSB];
		// close the window first; the summary carries the old start time
		if (TIME_W'(now_ticks - win_start) > TIME_W'(cfg_window)) begin
			if (cfg_stats) begin
				rec = '0;
				rec.kind = KIND_SUMMARY;
				rec.stamp = win_start;
				rec.wcount = win_cnt;
				rec.wsum = win_sum;
				rec.wsumsq = win_sq;
				rec.wmin = win_min;
				rec.wmax = win_max;
				predicted_records.push_back(rec);
			end
			clear_window();
			win_start = win_start + TIME_W'(cfg_window);
		end
		if (win_cnt != '1)
			win_cnt = win_cnt + 1'b1;
		win_sum = sat_add(win_sum, SUM_W'(pwr));
		win_sq = sat_add(win_sq, SUM_W'(pwr) * SUM_W'(pwr));
		if (pwr < win_min)
			win_min = pwr;
		if (pwr > win_max)
			win_max = pwr;
		rec = '0;
		rec.kind = KIND_SAMPLE;
		rec.power = pwr;
		rec.stamp = now_ticks;
		rec.last = is_last;
		predicted_records.push_back(rec);
		now_ticks = now_ticks + TIME_W'(period_q);
	endtask

	task automatic unpack_byte(input logic [7:0] b);
		if (frm_pos == 0) begin
			period_q = b;
		end else begin
			case ((int'(frm_pos) - 1) % 3)
				0: low_a = b;
				1: low_b = b;
				default: begin
					convert_sample({b[3:0], low_a}, 1'b0);
					convert_sample({b[7:4], low_b}, 1'b1);
				end
			endcase
		end
		frm_pos = (int'(frm_pos) + 1 >= FRAME_BYTES) ? '0 : frm_pos + 1'b1;
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endtask

	function automatic int send_gap_pct();
		if (bytes_in < 205)
			return 27;
		if (bytes_in < 410)
			return 77;
		return 0;
	endfunction

	function automatic int recv_gap_pct();
		if (bytes_in < 205)
			return 77;
		if (bytes_in < 410)
			return 27;
		return 0;
	endfunction

	// byte driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				unpack_byte(byte_value);
				bytes_in++;
			end
			if (!in_valid || in_ready) begin
				if (stream_bytes.size() != 0 && $urandom_range(0, 99) >= send_gap_pct()) begin
					in_valid <= 1'b1;
					byte_value <= stream_bytes.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		int            hold_next;
		logic          rdy;
		power_record_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
		end else begin
			hold_next = hold_left;
			if (out_valid && out_ready) begin
				if (predicted_records.size() == 0) begin
					$error("result transfer with no expectation pending");
					mismatches++;
				end else begin
					want = predicted_records.pop_front();
					check_field("kind", want.kind, kind);
					check_field("power", want.power, power);
					check_field("timestamp", want.stamp, timestamp);
					check_field("window_count", want.wcount, window_count);
					check_field("window_sum", want.wsum, window_sum);
					check_field("window_sum_squares", want.wsumsq, window_sum_squares);
					check_field("window_min", want.wmin, window_min);
					check_field("window_max", want.wmax, window_max);
					check_field("last", want.last, last);
				end
				if (kind == KIND_SUMMARY)
					n_summaries++;
				else
					n_samples++;
				// back up the pipeline while bytes keep coming
				if (n_samples + n_summaries == 100 || n_samples + n_summaries == 250)
					hold_next = LONG_HOLD;
			end
			if (hold_next > 0) begin
				hold_next--;
				rdy = 1'b0;
			end else begin
				rdy = ($urandom_range(0, 99) >= recv_gap_pct());
			end
			hold_left <= hold_next;
			out_ready <= rdy;
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		while (stall_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("Mismatches found");
		$finish;
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_POWER_SCALE: cfg_scale = val;
			REG_SECOND_TICKS: cfg_window = val;
			REG_STATS_ENABLE: cfg_stats = val[0];
			default: ;
		endcase
		cfg_writes++;
	endtask

	task automatic push_byte(input logic [7:0] b);
		stream_bytes.push_back(b);
		bytes_sent++;
		gen_pos = (gen_pos + 1 == FRAME_BYTES) ? 0 : gen_pos + 1;
	endtask

	task automatic push_triplet(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c);
		push_byte(a);
		push_byte(b);
		push_byte(c);
	endtask

	// loud: samples near full scale, to drive the square sum into saturation
	task automatic queue_bytes(input int count, input bit loud);
		logic [7:0] b;
		repeat (count) begin
			if (gen_pos == 0)
				b = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
			else if (loud)
				b = ((gen_pos - 1) % 3 == 2) ? 8'hFF : 8'($urandom_range(8'hE0, 8'hFF));
			else
				b = 8'($urandom);
			push_byte(b);
		end
	endtask

	task automatic drain();
		while (bytes_in != bytes_sent || predicted_records.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		reset_predictor();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// zero window: first sample sits on the window start, the next one closes it
		write_reg(REG_SECOND_TICKS, 32'd0);
		push_byte(8'hFF);
		push_triplet(8'h34, 8'h12, 8'hC5);
		drain();

		write_reg(REG_POWER_SCALE, 32'hFFFF_FFFF);
		write_reg(REG_STATS_ENABLE, 32'd1);
		write_reg(REG_UNUSED, 32'hFFFF_FFFF);
		push_triplet(8'hFF, 8'hFF, 8'hFF);
		push_triplet(8'h00, 8'h00, 8'h00);
		push_triplet(8'hFF, 8'h00, 8'h0F);
		push_triplet(8'h00, 8'hFF, 8'hF0);
		push_triplet(8'h5A, 8'hA5, 8'h5A);
		drain();

		write_reg(REG_POWER_SCALE, 32'd0);
		write_reg(REG_STATS_ENABLE, 32'hFFFF_FFFE);
		push_triplet(8'h12, 8'h34, 8'h56);
		drain();

		write_reg(REG_POWER_SCALE, $urandom);
		write_reg(REG_SECOND_TICKS, $urandom_range(1, 600));
		write_reg(REG_STATS_ENABLE, 32'd1);
		queue_bytes(24, 1'b0);
		drain();

		// windows keep closing, summaries suppressed
		write_reg(REG_STATS_ENABLE, {31'($urandom_range(0, 32'h7FFF_FFFF)), 1'b0});
		write_reg(REG_SECOND_TICKS, $urandom_range(1, 300));
		queue_bytes(18, 1'b0);
		drain();

		// one long window of loud samples
		write_reg(REG_POWER_SCALE, 32'hFFFF_FFFF);
		write_reg(REG_SECOND_TICKS, 32'hFFFF_FFFF);
		write_reg(REG_STATS_ENABLE, 32'd1);
		queue_bytes(410, 1'b1);
		drain();

		// zero window again: the saturated window closes, then every sample closes one
		write_reg(REG_SECOND_TICKS, 32'd0);
		write_reg(REG_POWER_SCALE, $urandom);
		queue_bytes(18, 1'b0);
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Covered %0d stream bytes: %0d sample results and %0d window summaries,",
			bytes_in, n_samples, n_summaries);
		$display("%0d register writes incl. zero and full-scale windows and power scales.",
			cfg_writes);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
